[sv/assert_macros.svh]
// Assertion macros shared by the message cache modules.
// Expect a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define MCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define MCT_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

[sv/mct_pkg.sv]
// Shared types and constants of the message cache with timeouts.
// Used by the controller, the datapath and the top level; no dependencies.
package mct_pkg;

   // Field widths of the stream words
   localparam int OPCODE_W  = 2;
   localparam int SOURCE_W  = 3;
   localparam int TIME_W    = 32;
   localparam int PAYLOAD_W = 64;
   localparam int LENGTH_W  = 8;
   localparam int MASK_W    = 6;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 72;

   // Configuration registers
   localparam int REG_COUNT = 6;
   localparam int TIMEOUT_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET [REG_COUNT] = '{
      16'd500, 16'd500, 16'd2000, 16'd2000, 16'd2000, 16'd200
   };

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CHECK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

   // Result status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic capture;   // latch the request word
      logic execute;   // apply the operation and load the result register
   } dp_cmd_type;

endpackage

[sv/mct_ctrl.sv]
// Controller of the message cache: sequences capture, execute and response.
// Depends on mct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mct_ctrl
   import mct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // hold off the request word while in reset
            req_tready  = !reset;
            cmd.capture = req_tvalid && !reset;
            if (req_tvalid && !reset) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            // hold the result word until the sink takes it
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `MCT_ASSERT(a_no_overlap, !(req_tready && rsp_tvalid), "request taken while result pending")
   `MCT_ASSERT_NEXT(a_accept_exec, req_tvalid && req_tready, cmd.execute, "accept without execute")
   `MCT_ASSERT_NEXT(a_exec_resp, cmd.execute, rsp_tvalid, "execute without result word")

endmodule

[sv/mct_dpath.sv]
// Datapath of the message cache: request register, entry store, timeout
// registers, parallel age compares and the result register. Depends on mct_pkg.
module mct_dpath
   import mct_pkg::*;
#(
   parameter int NUM_SOURCES     = 6,
   parameter int BYTES_PER_ENTRY = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   // request fields
   input  logic [OPCODE_W-1:0]   opcode,
   input  logic [SOURCE_W-1:0]   source,
   input  logic [TIME_W-1:0]     now_ms,
   input  logic [PAYLOAD_W-1:0]  payload_in,
   input  logic [LENGTH_W-1:0]   length,
   // configuration writes
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIMEOUT_W-1:0]  csr_data,
   // result fields
   output logic                  status,
   output logic [PAYLOAD_W-1:0]  payload_out,
   output logic                  stale,
   output logic [MASK_W-1:0]     stale_mask
);

   localparam int ENTRY_W = 8 * BYTES_PER_ENTRY;

   // Request register
   logic [OPCODE_W-1:0]  op_ff;
   logic [SOURCE_W-1:0]  src_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [PAYLOAD_W-1:0] data_ff;
   logic [LENGTH_W-1:0]  len_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= opcode;
         src_ff  <= source;
         now_ff  <= now_ms;
         data_ff <= payload_in;
         len_ff  <= length;
      end
   end

   // Timeout registers
   logic [TIMEOUT_W-1:0] timeout_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < REG_COUNT; r++) begin
            timeout_ff[r] <= TIMEOUT_RESET[r];
         end
      end else if (csr_write) begin
         for (int r = 0; r < REG_COUNT; r++) begin
            if (csr_index == CSR_IDX_W'(r)) begin
               timeout_ff[r] <= csr_data;
            end
         end
      end
   end

   // Entry store
   logic [ENTRY_W-1:0] payload_ff [NUM_SOURCES];
   logic [TIME_W-1:0]  time_ff    [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] seen_ff, seen_in;
   logic [NUM_SOURCES-1:0] stale_ff, stale_in;

   logic [NUM_SOURCES-1:0] hit;
   logic [NUM_SOURCES-1:0] expired;
   logic [ENTRY_W-1:0]     clipped;
   logic [TIME_W-1:0]      age [NUM_SOURCES];
   logic                   src_ok;
   logic                   wr_entry;

   always_comb begin
      src_ok = (src_ff < SOURCE_W'(NUM_SOURCES));
      for (int i = 0; i < NUM_SOURCES; i++) begin
         hit[i]     = (src_ff == SOURCE_W'(i));
         age[i]     = now_ff - time_ff[i];
         expired[i] = seen_ff[i] && (age[i] > TIME_W'(timeout_ff[i]));
      end
      // keep byte b only when it lies below the length; longer lengths clip
      for (int b = 0; b < BYTES_PER_ENTRY; b++) begin
         clipped[8*b +: 8] = (LENGTH_W'(b) < len_ff) ? data_ff[8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      seen_in  = seen_ff;
      stale_in = stale_ff;
      wr_entry = 1'b0;
      unique case (op_ff)
         OP_UPDATE: begin
            if (src_ok) begin
               wr_entry = 1'b1;
               seen_in  = seen_ff | hit;
               stale_in = stale_ff & ~hit;
            end
         end
         OP_CHECK: begin
            stale_in = stale_ff | expired;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         stale_ff <= '0;
      end else if (cmd.execute) begin
         seen_ff  <= seen_in;
         stale_ff <= stale_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && wr_entry) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            if (hit[i]) begin
               payload_ff[i] <= clipped;
               time_ff[i]    <= now_ff;
            end
         end
      end
   end

   // Result assembly
   logic [ENTRY_W-1:0] rd_payload;
   logic               rd_seen;
   logic               rd_stale;
   logic               status_in;
   logic [PAYLOAD_W-1:0] payload_out_in;
   logic               stale_in_bit;
   logic [MASK_W-1:0]  mask_in;

   always_comb begin
      rd_payload = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         rd_payload = rd_payload | (hit[i] ? payload_ff[i] : '0);
      end
      rd_seen  = |(hit & seen_ff);
      rd_stale = |(hit & stale_ff);

      status_in      = STATUS_OK;
      payload_out_in = '0;
      stale_in_bit   = 1'b0;
      unique case (op_ff)
         OP_UPDATE: begin
            if (!src_ok) begin
               status_in = STATUS_ERR;
            end
         end
         OP_READ: begin
            if (!src_ok || !rd_seen) begin
               status_in = STATUS_ERR;
            end else begin
               payload_out_in = PAYLOAD_W'(rd_payload);
               stale_in_bit   = rd_stale;
            end
         end
         default: begin
         end
      endcase

      mask_in = '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
         mask_in[i] = stale_in[i];
      end
   end

   logic                 status_ff;
   logic [PAYLOAD_W-1:0] payload_out_ff;
   logic                 stale_out_ff;
   logic [MASK_W-1:0]    mask_ff;

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff      <= status_in;
         payload_out_ff <= payload_out_in;
         stale_out_ff   <= stale_in_bit;
         mask_ff        <= mask_in;
      end
   end

   assign status      = status_ff;
   assign payload_out = payload_out_ff;
   assign stale       = stale_out_ff;
   assign stale_mask  = mask_ff;

endmodule

[sv/message_cache_with_timeouts.sv]
// Message cache with per-source timeout supervision: one request word in,
// one result word out. The three-state controller (capture, execute, respond)
// takes a request word only in its idle state, so a new request word is taken
// only after the sink has taken the previous result word.
// Reset: synchronous, active high; clears flags and restores the timeouts.
module message_cache_with_timeouts
   import mct_pkg::*;
#(
   parameter int NUM_SOURCES     = 6,
   parameter int BYTES_PER_ENTRY = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // source, now_ms, payload_in, length, zero pad
   input  logic [OPCODE_W-1:0]   req_tuser,  // opcode
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // payload_out, stale, stale_mask, zero pad
   output logic                  rsp_tuser,  // status
   // configuration writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIMEOUT_W-1:0]  csr_data
);

   localparam int NOW_LO = SOURCE_W;
   localparam int PAY_LO = NOW_LO + TIME_W;
   localparam int LEN_LO = PAY_LO + PAYLOAD_W;

   dp_cmd_type           cmd;
   logic [PAYLOAD_W-1:0] payload_out;
   logic                 stale;
   logic [MASK_W-1:0]    stale_mask;

   assign csr_ready = !reset;

   mct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   mct_dpath #(
      .NUM_SOURCES     (NUM_SOURCES),
      .BYTES_PER_ENTRY (BYTES_PER_ENTRY)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .opcode      (req_tuser),
      .source      (req_tdata[SOURCE_W-1:0]),
      .now_ms      (req_tdata[NOW_LO +: TIME_W]),
      .payload_in  (req_tdata[PAY_LO +: PAYLOAD_W]),
      .length      (req_tdata[LEN_LO +: LENGTH_W]),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .status      (rsp_tuser),
      .payload_out (payload_out),
      .stale       (stale),
      .stale_mask  (stale_mask)
   );

   assign rsp_tdata = {1'b0, stale_mask, stale, payload_out};

endmodule

[verif/cache_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the message cache with timeouts: mirrors the cached payloads,
// update times, flags and timeout registers, and compares every result word.
// Depends on mct_pkg for field widths, register count and operation codes.
module cache_result_checker
   import mct_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [OPCODE_W-1:0]   req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [TIMEOUT_W-1:0]  csr_data,
   output int                    mismatch_count,
   output int                    results_owed
);

   localparam int SOURCE_COUNT = 6;
   localparam int ENTRY_BYTES  = 8;

   localparam int TIME_LSB    = SOURCE_W;
   localparam int PAYLOAD_LSB = SOURCE_W + TIME_W;
   localparam int LENGTH_LSB  = SOURCE_W + TIME_W + PAYLOAD_W;

   typedef struct packed {
      logic                 status;
      logic [PAYLOAD_W-1:0] payload;
      logic                 stale;
      logic [MASK_W-1:0]    stale_mask;
   } cache_result_type;

   logic [PAYLOAD_W-1:0] cached_payload [SOURCE_COUNT];
   logic [TIME_W-1:0]    update_ms      [SOURCE_COUNT];
   logic                 received       [SOURCE_COUNT];
   logic                 stale_flag     [SOURCE_COUNT];
   logic [TIMEOUT_W-1:0] timeout_ms     [REG_COUNT];
   cache_result_type     results_due    [$];
   int                   fail_tally = 0;

   function automatic cache_result_type apply_request(
      logic [OPCODE_W-1:0]  op,
      logic [SOURCE_W-1:0]  src,
      logic [TIME_W-1:0]    now,
      logic [PAYLOAD_W-1:0] data,
      logic [LENGTH_W-1:0]  len
   );
      cache_result_type     res;
      logic [PAYLOAD_W-1:0] keep;
      logic [TIME_W-1:0]    age;
      int                   nbytes;
      res = '0;
      unique case (op)
         OP_UPDATE: begin
            if (src >= SOURCE_COUNT) begin
               res.status = STATUS_ERR;
            end else begin
               nbytes = (len > ENTRY_BYTES) ? ENTRY_BYTES : int'(len);
               keep = (nbytes == ENTRY_BYTES) ? '1 : ((64'd1 << (8 * nbytes)) - 64'd1);
               cached_payload[src] = data & keep;
               update_ms[src]      = now;
               received[src]       = 1'b1;
               stale_flag[src]     = 1'b0;
            end
         end
         OP_CHECK: begin
            for (int i = 0; i < SOURCE_COUNT; i++) begin
               age = now - update_ms[i];
               if (received[i] && age > {16'd0, timeout_ms[i]})
                  stale_flag[i] = 1'b1;
            end
         end
         OP_READ: begin
            if (src >= SOURCE_COUNT || !received[src]) begin
               res.status = STATUS_ERR;
            end else begin
               res.payload = cached_payload[src];
               res.stale   = stale_flag[src];
            end
         end
         default: ;
      endcase
      for (int i = 0; i < SOURCE_COUNT; i++)
         res.stale_mask[i] = stale_flag[i];
      return res;
   endfunction

   always @(posedge clock) begin
      cache_result_type got;
      cache_result_type want;
      if (reset) begin
         for (int i = 0; i < SOURCE_COUNT; i++) begin
            cached_payload[i] = '0;
            update_ms[i]      = '0;
            received[i]       = 1'b0;
            stale_flag[i]     = 1'b0;
         end
         for (int i = 0; i < REG_COUNT; i++)
            timeout_ms[i] = TIMEOUT_RESET[i];
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index < REG_COUNT)
            timeout_ms[csr_index] = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            got.status     = rsp_tuser;
            got.payload    = rsp_tdata[PAYLOAD_W-1:0];
            got.stale      = rsp_tdata[PAYLOAD_W];
            got.stale_mask = rsp_tdata[PAYLOAD_W+1 +: MASK_W];
            if (results_due.size() == 0) begin
               $error("result word with nothing outstanding: %h", rsp_tdata);
               fail_tally++;
            end else begin
               want = results_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0h, got %0h", want.status, got.status);
                  fail_tally++;
               end
               if (got.payload !== want.payload) begin
                  $error("payload_out: expected %h, got %h", want.payload, got.payload);
                  fail_tally++;
               end
               if (got.stale !== want.stale) begin
                  $error("stale: expected %0h, got %0h", want.stale, got.stale);
                  fail_tally++;
               end
               if (got.stale_mask !== want.stale_mask) begin
                  $error("stale_mask: expected %h, got %h", want.stale_mask,
                         got.stale_mask);
                  fail_tally++;
               end
            end
         end

         if (req_tvalid && req_tready)
            results_due.push_back(apply_request(req_tuser,
                                                req_tdata[SOURCE_W-1:0],
                                                req_tdata[TIME_LSB +: TIME_W],
                                                req_tdata[PAYLOAD_LSB +: PAYLOAD_W],
                                                req_tdata[LENGTH_LSB +: LENGTH_W]));
      end
      mismatch_count <= fail_tally;
      results_owed   <= results_due.size();
   end

endmodule

[verif/message_cache_with_timeouts_tb.sv]
`timescale 1ns / 1ps
// Top of the message cache testbench: clock, reset, request and timeout
// stimulus, result back-pressure and the verdict. Uses mct_pkg and the
// cache_result_checker module, which predicts and compares the result words.
module message_cache_with_timeouts_tb;
   import mct_pkg::*;

   localparam int SOURCE_COUNT   = 6;
   localparam int PHASE_COUNT    = 6;
   localparam int ITEMS_PER_PHASE = 305;
   localparam int LONG_HOLD      = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int CYCLE_LIMIT    = 600000;

   localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

   typedef enum {
      PROF_ZERO,
      PROF_MAX,
      PROF_TINY,
      PROF_FULL,
      PROF_MIXED,
      PROF_SHORT
   } timeout_profile_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // source, now_ms, payload_in, length, zero pad
   logic [OPCODE_W-1:0]   req_tuser;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // payload_out, stale, stale_mask, zero pad
   logic                  rsp_tuser;   // status
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [TIMEOUT_W-1:0]  csr_data;

   int mismatch_count;
   int results_owed;

   // stimulus bookkeeping, used to aim checks at the timeout boundary
   logic [TIME_W-1:0]    t_cur;
   logic [TIME_W-1:0]    last_update_ms [SOURCE_COUNT];
   logic [TIMEOUT_W-1:0] timeout_written [SOURCE_COUNT];
   bit                   quiet;
   bit                   hold_request;
   bit                   hold_served;

   message_cache_with_timeouts i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cache_result_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // result side: random stall bursts, one long hold-off, none when quiet
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   task automatic send_req(logic [OPCODE_W-1:0] op, logic [SOURCE_W-1:0] src,
                           logic [TIME_W-1:0] now, logic [PAYLOAD_W-1:0] data,
                           logic [LENGTH_W-1:0] len);
      logic [REQ_DATA_W-1:0] word;
      int                    gap;
      word = '0;
      word[SOURCE_W-1:0] = src;
      word[SOURCE_W +: TIME_W] = now;
      word[SOURCE_W+TIME_W +: PAYLOAD_W] = data;
      word[SOURCE_W+TIME_W+PAYLOAD_W +: LENGTH_W] = len;
      gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_timeout(int idx, logic [TIMEOUT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx < SOURCE_COUNT)
         timeout_written[idx] = value;
   endtask

   // drop the request and wait until every result word has come back
   task automatic wait_drained(int extra);
      @(negedge clock);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic load_timeouts(timeout_profile_type prof);
      logic [TIMEOUT_W-1:0] value;
      for (int i = 0; i < REG_COUNT; i++) begin
         unique case (prof)
            PROF_ZERO:  value = '0;
            PROF_MAX:   value = '1;
            PROF_TINY:  value = TIMEOUT_W'($urandom_range(0, 64));
            PROF_FULL:  value = TIMEOUT_W'($urandom_range(0, 65535));
            PROF_MIXED: value = (i % 3 == 0) ? 16'd0 :
                                (i % 3 == 1) ? 16'hFFFF : 16'($urandom_range(1, 200));
            default:    value = TIMEOUT_W'($urandom_range(0, 300));
         endcase
         write_timeout(i, value);
      end
      // indexes past the last register are dropped by the block
      write_timeout(int'($urandom_range(REG_COUNT, 7)), TIMEOUT_W'($urandom_range(0, 65535)));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic int time_span(timeout_profile_type prof);
      unique case (prof)
         PROF_ZERO:  return 3;
         PROF_MAX:   return 20000;
         PROF_TINY:  return 40;
         PROF_FULL:  return 20000;
         PROF_MIXED: return 120;
         default:    return 150;
      endcase
   endfunction

   task automatic send_random_item(int span);
      logic [OPCODE_W-1:0]  op;
      logic [SOURCE_W-1:0]  src;
      logic [TIME_W-1:0]    now;
      logic [LENGTH_W-1:0]  len;
      int                   pick;
      int                   target;
      t_cur = t_cur + $urandom_range(0, span);
      pick = $urandom_range(0, 99);
      op = (pick < 40) ? OP_UPDATE : (pick < 70) ? OP_CHECK :
           (pick < 95) ? OP_READ : OP_SPARE;
      src = ($urandom_range(0, 9) < 9) ? SOURCE_W'($urandom_range(0, SOURCE_COUNT - 1)) :
                                         SOURCE_W'($urandom_range(SOURCE_COUNT, 7));
      len = ($urandom_range(0, 3) == 0) ? LENGTH_W'($urandom_range(0, 255)) :
                                          LENGTH_W'($urandom_range(0, 8));
      now = t_cur;
      if ($urandom_range(0, 99) < 8) begin
         now = $urandom;
      end else if (op == OP_CHECK && $urandom_range(0, 3) == 0) begin
         // land right on or just past one source's timeout
         target = $urandom_range(0, SOURCE_COUNT - 1);
         now = last_update_ms[target] + TIME_W'(timeout_written[target]) +
               $urandom_range(0, 1);
      end
      if (op == OP_UPDATE && src < SOURCE_COUNT)
         last_update_ms[src] = now;
      send_req(op, src, now, {$urandom, $urandom}, len);
   endtask

   timeout_profile_type phase_profile [PHASE_COUNT] = '{
      PROF_ZERO, PROF_MAX, PROF_TINY, PROF_FULL, PROF_MIXED, PROF_SHORT
   };

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      hold_served  = 1'b0;
      t_cur        = '0;
      for (int i = 0; i < SOURCE_COUNT; i++) begin
         last_update_ms[i]  = '0;
         timeout_written[i] = TIMEOUT_RESET[i];
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass on the reset timeouts
      send_req(OP_READ,   3'd0, 32'd0,    64'h0, 8'd0);   // read before any update
      send_req(OP_UPDATE, 3'd0, 32'd1000, '1,    8'd8);
      send_req(OP_READ,   3'd0, 32'd0,    64'h0, 8'd0);
      send_req(OP_UPDATE, 3'd1, 32'd1000, 64'h0123456789ABCDEF, 8'd0);
      send_req(OP_UPDATE, 3'd2, 32'd1000, 64'hFEDCBA9876543210, 8'd3);
      send_req(OP_UPDATE, 3'd3, 32'd1000, '1, 8'd9);
      send_req(OP_UPDATE, 3'd4, 32'd1000, 64'hA5A5A5A55A5A5A5A, 8'd255);
      send_req(OP_UPDATE, 3'd5, 32'd1000, '1, 8'd7);
      send_req(OP_CHECK,  3'd7, 32'd1500, '1, 8'd255);    // age equal to timeout
      send_req(OP_CHECK,  3'd0, 32'd1501, 64'h0, 8'd0);
      send_req(OP_READ,   3'd0, 32'd0, 64'h0, 8'd0);
      send_req(OP_READ,   3'd2, 32'd0, 64'h0, 8'd0);
      send_req(OP_UPDATE, 3'd6, 32'd2000, '1, 8'd8);       // bad source
      send_req(OP_UPDATE, 3'd7, 32'hFFFFFFFF, '1, 8'd8);
      send_req(OP_READ,   3'd6, 32'd0, 64'h0, 8'd0);
      send_req(OP_READ,   3'd7, 32'd0, 64'h0, 8'd0);
      send_req(OP_SPARE,  3'd7, 32'hFFFFFFFF, '1, 8'd255);
      send_req(OP_CHECK,  3'd0, 32'd3001, 64'h0, 8'd0);
      send_req(OP_UPDATE, 3'd0, 32'hFFFFFF00, 64'h00000000000000FF, 8'd1);
      send_req(OP_CHECK,  3'd0, 32'h000000F4, 64'h0, 8'd0);   // wrapped age at timeout
      send_req(OP_CHECK,  3'd0, 32'h000000F5, 64'h0, 8'd0);
      send_req(OP_READ,   3'd0, 32'd0, 64'h0, 8'd0);
      send_req(OP_READ,   3'd5, 32'd0, 64'h0, 8'd0);
      send_req(OP_UPDATE, 3'd1, 32'd0, 64'h0, 8'd8);
      send_req(OP_READ,   3'd1, 32'd0, 64'h0, 8'd0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained(4);
         if (phase == PHASE_COUNT - 1)
            quiet = 1'b1;
         load_timeouts(phase_profile[phase]);
         t_cur = (phase == 1) ? 32'hFFFFF000 : $urandom;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 2 && n == 50)
               hold_request = 1'b1;
            send_random_item(time_span(phase_profile[phase]));
         end
      end

      wait_drained(DRAIN_CYCLES);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
